// ===== design/cfd_pkg.sv =====
// Shared types and constants for the COBS frame decoder.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package cfd_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam logic [15:0] MaxOutLenReset = 16'hFFFF;

	localparam logic [7:0] CodeFull  = 8'hFF;
	localparam logic [7:0] ZeroByte  = 8'h00;

	// Register map (index into register list)
	localparam logic RegMaxOutLen = 1'b0;

	// Result kinds; KIND_BYTE also serves as "no error" in the error register
	typedef enum logic [1:0] {
		KIND_BYTE      = 2'd0,
		KIND_OK        = 2'd1,
		KIND_MALFORMED = 2'd2,
		KIND_OVERFLOW  = 2'd3
	} kind_t;

	// Work handed from the front end to the result stage for one input byte
	typedef struct packed {
		logic        has_byte;
		logic [7:0]  data;
		logic        has_status;
		kind_t       kind;
		logic [15:0] length;
	} cmd_t;

endpackage

`default_nettype wire

// ===== design/cfd_front.sv =====
// Front end: accepts encoded bytes, tracks block state and builds result commands.
// Depends on cfd_pkg.
`default_nettype none

module cfd_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire logic [15:0] max_out_len,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire              frame_end,
	output logic             cmd_valid,
	input  wire              cmd_ready,
	output cfd_pkg::cmd_t    cmd
);

	logic [7:0]     block_rem_q, block_rem_d;
	logic           zero_owed_q, zero_owed_d;
	logic [15:0]    count_q, count_d;
	cfd_pkg::kind_t err_q, err_d;

	logic       is_delim;
	logic       try_emit;
	logic [7:0] emit_val;
	logic       ovf;
	logic       accept;

	assign in_ready = cmd_ready;
	assign accept   = in_valid && cmd_ready;
	assign is_delim = frame_end && (in_byte == cfd_pkg::ZeroByte);

	always_comb begin
		block_rem_d = block_rem_q;
		zero_owed_d = zero_owed_q;
		count_d     = count_q;
		err_d       = err_q;
		try_emit    = 1'b0;
		emit_val    = cfd_pkg::ZeroByte;
		cmd         = '0;

		if (!is_delim && err_q == cfd_pkg::KIND_BYTE) begin
			if (block_rem_q != 8'd0) begin
				try_emit    = 1'b1;
				emit_val    = in_byte;
				block_rem_d = block_rem_q - 8'd1;
			end else begin
				// pay the zero owed by the previous block
				try_emit    = zero_owed_q;
				zero_owed_d = 1'b0;
			end
		end

		ovf = try_emit && (count_q >= max_out_len);
		cmd.has_byte = try_emit && !ovf;
		cmd.data     = emit_val;
		if (ovf) begin
			err_d = cfd_pkg::KIND_OVERFLOW;
		end
		if (cmd.has_byte) begin
			count_d = count_q + 16'd1;
		end

		// code byte opens a new block
		if (!is_delim && err_q == cfd_pkg::KIND_BYTE && block_rem_q == 8'd0 && !ovf) begin
			if (in_byte == cfd_pkg::ZeroByte) begin
				err_d = cfd_pkg::KIND_MALFORMED;
			end else begin
				block_rem_d = in_byte - 8'd1;
				zero_owed_d = (in_byte != cfd_pkg::CodeFull);
			end
		end

		if (frame_end) begin
			if (err_d == cfd_pkg::KIND_BYTE && block_rem_d != 8'd0) begin
				err_d = cfd_pkg::KIND_MALFORMED;
			end
			cmd.has_status = 1'b1;
			if (err_d == cfd_pkg::KIND_BYTE) begin
				cmd.kind   = cfd_pkg::KIND_OK;
				cmd.length = count_d;
			end else begin
				cmd.kind   = err_d;
				cmd.length = 16'd0;
			end
			block_rem_d = 8'd0;
			zero_owed_d = 1'b0;
			count_d     = 16'd0;
			err_d       = cfd_pkg::KIND_BYTE;
		end
	end

	// drop bytes that cause no result
	assign cmd_valid = in_valid && (cmd.has_byte || cmd.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_rem_q <= 8'd0;
			zero_owed_q <= 1'b0;
			count_q     <= 16'd0;
			err_q       <= cfd_pkg::KIND_BYTE;
		end else if (accept) begin
			block_rem_q <= block_rem_d;
			zero_owed_q <= zero_owed_d;
			count_q     <= count_d;
			err_q       <= err_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/cfd_queue.sv =====
// Small show-ahead queue of result commands between front end and result stage.
// Depends on cfd_pkg.
`default_nettype none

module cfd_queue #(
	parameter int unsigned DEPTH = cfd_pkg::QueueDepth
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push_valid,
	output logic          push_ready,
	input  cfd_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  wire           pop_ready,
	output cfd_pkg::cmd_t pop_cmd
);

	localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
	localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

	cfd_pkg::cmd_t   slots_q [DEPTH];
	logic [IdxW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign push_ready = (count_q != Full);
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/cfd_back.sv =====
// Result stage: expands each command into one or two results in an output register.
// Depends on cfd_pkg.
`default_nettype none

module cfd_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cmd_valid,
	output logic             cmd_ready,
	input  cfd_pkg::cmd_t    cmd,
	output logic             out_valid,
	input  wire              out_ready,
	output cfd_pkg::kind_t   out_kind,
	output logic [7:0]       out_byte,
	output logic [15:0]      out_length,
	output logic             out_last
);

	logic           valid_q;
	cfd_pkg::kind_t kind_q;
	logic [7:0]     byte_q;
	logic [15:0]    length_q;
	logic           last_q;
	logic           byte_done_q;

	logic slot_free;
	logic load;
	logic send_byte;

	assign slot_free = !valid_q || out_ready;
	assign load      = slot_free && cmd_valid;
	// byte goes first; status follows in the next slot
	assign send_byte = cmd.has_byte && !byte_done_q;
	assign cmd_ready = slot_free && !(send_byte && cmd.has_status);

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_byte) begin
				kind_q   <= cfd_pkg::KIND_BYTE;
				byte_q   <= cmd.data;
				length_q <= 16'd0;
				last_q   <= !cmd.has_status;
			end else begin
				kind_q   <= cmd.kind;
				byte_q   <= 8'd0;
				length_q <= cmd.length;
				last_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			byte_done_q <= 1'b0;
		end else begin
			if (slot_free) begin
				valid_q <= cmd_valid;
			end
			if (load) begin
				byte_done_q <= send_byte && cmd.has_status;
			end
		end
	end

	assign out_valid  = valid_q;
	assign out_kind   = kind_q;
	assign out_byte   = byte_q;
	assign out_length = length_q;
	assign out_last   = last_q;

endmodule

`default_nettype wire

// ===== design/cobs_frame_decoder.sv =====
// COBS frame decoder top level: register port, front end, command queue, result stage.
// Depends on cfd_pkg, cfd_front, cfd_queue, cfd_back.
//
// Usage: encoded bytes enter on the s_* stream, one per transaction, with s_tlast on
// the last byte of a frame buffer. Decoded bytes and one status per frame leave on
// the m_* stream; m_tuser gives the kind (byte, ok, malformed, overflow) and m_tlast
// marks the final result caused by an input byte. A trailing zero is the delimiter.
// Bytes emitted before an error status belong to a failed frame and are to be dropped.
// Throughput: one input byte per cycle while s_tready is high. Each byte causes zero,
// one or two results and the output register sends one result per cycle while m_tready
// is high, so a byte that yields both a data byte and the status holds the output
// register for both; the command queue (QUEUE_DEPTH entries) absorbs that. Order: a
// command enters the queue at the accepting edge and the output register once that
// register is free; a status that follows a data byte leaves after that byte.
// Stalls: when m_tready is low the output register holds, the queue fills and then
// s_tready drops; no result is lost. Reset clears all frame state, empties the
// queue and sets max_out_len to 65535. Write max_out_len (address 0) only when idle.
`default_nettype none

module cobs_frame_decoder #(
	parameter int unsigned QUEUE_DEPTH = cfd_pkg::QueueDepth
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire              s_tlast,
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] frame_length
	output logic [1:0]       m_tuser,   // [1:0] result_kind
	output logic             m_tlast,
	input  wire              psel,
	input  wire              penable,
	input  wire              pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [15:0]    max_out_len_q;
	logic           reg_write;
	logic           push_valid, push_ready;
	cfd_pkg::cmd_t  push_cmd;
	logic           pop_valid, pop_ready;
	cfd_pkg::cmd_t  pop_cmd;
	cfd_pkg::kind_t out_kind;
	logic [7:0]     out_byte;
	logic [15:0]    out_length;

	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready && (paddr[2] == cfd_pkg::RegMaxOutLen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_out_len_q <= cfd_pkg::MaxOutLenReset;
		end else if (reg_write) begin
			max_out_len_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == cfd_pkg::RegMaxOutLen) begin
			prdata = {16'd0, max_out_len_q};
		end
	end

	cfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_out_len (max_out_len_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_byte     (s_tdata),
		.frame_end   (s_tlast),
		.cmd_valid   (push_valid),
		.cmd_ready   (push_ready),
		.cmd         (push_cmd)
	);

	cfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	cfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (pop_valid),
		.cmd_ready  (pop_ready),
		.cmd        (pop_cmd),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.out_length (out_length),
		.out_last   (m_tlast)
	);

	assign m_tdata = {out_length, out_byte};
	assign m_tuser = out_kind;

endmodule

`default_nettype wire

// ===== design/cfd_checker.sv =====
// Port-level checks for the COBS frame decoder, bound to the top level.
// Depends on cfd_pkg and cobs_frame_decoder.
`default_nettype none

module cfd_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              m_tvalid,
	input wire              m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire              m_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// a status always closes the run of its input byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != cfd_pkg::KIND_BYTE |-> m_tlast)
		else $error("status result without tlast");

	// error status reports zero length and no byte
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == cfd_pkg::KIND_MALFORMED || m_tuser == cfd_pkg::KIND_OVERFLOW)
			|-> m_tdata == 24'd0)
		else $error("error status carries data");

	// decoded byte carries no length
	a_byte_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cfd_pkg::KIND_BYTE |-> m_tdata[23:8] == 16'd0)
		else $error("decoded byte carries a length");

endmodule

bind cobs_frame_decoder cfd_checker u_cfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// ===== sim/cobs_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the COBS frame decoder testbench: watches both streams and the APB port,
// predicts every result and compares it with the m_* stream. Depends on cfd_pkg.

module cobs_result_checker (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	input  wire              s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire              s_tlast,
	input  wire              m_tvalid,
	input  wire              m_tready,
	input  wire logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] frame_length
	input  wire logic [1:0]  m_tuser,   // [1:0] result_kind
	input  wire              m_tlast,
	input  wire              psel,
	input  wire              penable,
	input  wire              pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire              pready,
	output int               results_due,
	output int               mismatch_cnt
);

	import cfd_pkg::*;

	localparam logic [2:0] CapAddr = {RegMaxOutLen, 2'b00};

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] length;
		logic        last;
	} result_t;

	result_t     due_q[$];
	result_t     step_q[$];

	logic [7:0]  block_left;
	logic        zero_due;
	logic [15:0] byte_cnt;
	kind_t       frame_err;   // KIND_BYTE means no error
	logic [15:0] cap;

	function automatic void emit_decoded(input logic [7:0] val);
		if (byte_cnt >= cap) begin
			frame_err = KIND_OVERFLOW;
		end else begin
			step_q.push_back('{KIND_BYTE, val, 16'd0, 1'b0});
			byte_cnt++;
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic fin);
		step_q.delete();
		if (!(fin && b == ZeroByte) && frame_err == KIND_BYTE) begin
			if (block_left != 8'd0) begin
				emit_decoded(b);
				block_left--;
			end else begin
				// settle the zero owed by the previous block before looking at the code
				if (zero_due) begin
					emit_decoded(ZeroByte);
					zero_due = 1'b0;
				end
				if (frame_err == KIND_BYTE) begin
					if (b == ZeroByte) begin
						frame_err = KIND_MALFORMED;
					end else begin
						block_left = b - 8'd1;
						zero_due = (b != CodeFull);
					end
				end
			end
		end
		if (fin) begin
			if (frame_err == KIND_BYTE && block_left != 8'd0)
				frame_err = KIND_MALFORMED;
			if (frame_err == KIND_BYTE)
				step_q.push_back('{KIND_OK, 8'd0, byte_cnt, 1'b0});
			else
				step_q.push_back('{frame_err, 8'd0, 16'd0, 1'b0});
			block_left = 8'd0;
			zero_due = 1'b0;
			byte_cnt = 16'd0;
			frame_err = KIND_BYTE;
		end
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i])
			due_q.push_back(step_q[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		result_t got;
		result_t want;
		if (!arst_n) begin
			due_q.delete();
			block_left = 8'd0;
			zero_due = 1'b0;
			byte_cnt = 16'd0;
			frame_err = KIND_BYTE;
			cap = MaxOutLenReset;
			results_due = 0;
			mismatch_cnt = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == CapAddr)
				cap = pwdata[15:0];
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got = '{kind_t'(m_tuser), m_tdata[7:0], m_tdata[23:8], m_tlast};
				if (due_q.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("%0t: unexpected transaction kind=%0d byte=%02h len=%0d last=%0b",
							$realtime, got.kind, got.data, got.length, got.last);
					mismatch_cnt++;
				end else begin
					want = due_q.pop_front();
					if (got.kind !== want.kind || got.data !== want.data ||
						got.length !== want.length || got.last !== want.last) begin
						if (mismatch_cnt < 10)
							$display({"%0t: mismatch expected kind=%0d byte=%02h len=%0d last=%0b,",
								" got kind=%0d byte=%02h len=%0d last=%0b"}, $realtime,
								want.kind, want.data, want.length, want.last,
								got.kind, got.data, got.length, got.last);
						mismatch_cnt++;
					end
				end
			end
			results_due = due_q.size();
		end
	end

endmodule

// ===== sim/tb_cobs_frame_decoder.sv =====
`timescale 1ns / 1ps
// Top of the COBS frame decoder testbench: clock, reset, stimulus, APB writes and verdict.
// Depends on cfd_pkg, cobs_frame_decoder and cobs_result_checker.

module tb_cobs_frame_decoder;

	import cfd_pkg::*;

	localparam logic [2:0] CapAddr = {RegMaxOutLen, 2'b00};
	localparam int CycleLimit = 300000;
	localparam int PhaseBytes = 40;

	localparam int SrcIdlePct[3] = '{15, 74, 0};
	localparam int SnkIdlePct[3] = '{74, 15, 0};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          results_due;
	int          mismatch_cnt;
	int          src_pct;
	int          snk_pct;
	int          sent_bytes;
	int          cycle_cnt;
	logic [7:0]  frame_q[$];

	cobs_frame_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	cobs_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.results_due  (results_due),
		.mismatch_cnt (mismatch_cnt)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < src_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		sent_bytes++;
	endtask

	task automatic send_frame(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// Drop valid and wait until every predicted result has left, plus pipeline slack.
	task automatic hold_until_drained();
		s_tvalid = 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cap(input logic [15:0] val);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = CapAddr;
		pwdata = {16'($urandom), val};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Build one frame: mostly proper encodings, some broken ones, some noise, some bare delimiters.
	function automatic void make_frame();
		logic [7:0] payload[$];
		logic [7:0] code;
		int         code_at;
		int         plen;
		int         sel;
		int         cut;
		frame_q.delete();
		sel = $urandom_range(99);
		if (sel < 80) begin
			plen = $urandom_range(0, 20);
			repeat (plen)
				payload.push_back(($urandom_range(3) == 0) ?
					ZeroByte : 8'($urandom_range(1, 255)));
			code_at = 0;
			code = 8'd1;
			frame_q.push_back(ZeroByte);
			foreach (payload[i]) begin
				if (payload[i] != ZeroByte) begin
					frame_q.push_back(payload[i]);
					code++;
				end
				if (payload[i] == ZeroByte || code == CodeFull) begin
					frame_q[code_at] = code;
					code_at = frame_q.size();
					frame_q.push_back(ZeroByte);
					code = 8'd1;
				end
			end
			frame_q[code_at] = code;
			if (sel >= 70) begin
				if (frame_q.size() > 1 && $urandom_range(1) == 1) begin
					cut = $urandom_range(1, frame_q.size() - 1);
					while (frame_q.size() > cut) void'(frame_q.pop_back());
				end else begin
					frame_q.insert($urandom_range(0, frame_q.size() - 1), ZeroByte);
				end
			end
			if ($urandom_range(9) != 0)
				frame_q.push_back(ZeroByte);
		end else if (sel < 92) begin
			repeat ($urandom_range(1, 8))
				frame_q.push_back(($urandom_range(3) == 0) ? ZeroByte : 8'($urandom_range(255)));
		end else begin
			frame_q.push_back(ZeroByte);
			if ($urandom_range(1) == 1)
				frame_q.push_back(ZeroByte);
		end
	endfunction

	initial begin : stimulus
		int phase_end;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'd0;
		sent_bytes = 0;
		cycle_cnt = 0;
		src_pct = SrcIdlePct[0];
		snk_pct = SnkIdlePct[0];
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// delimiter only, plain blocks, zero inside a block, zero code, truncation
		send_frame('{8'h00});
		send_frame('{8'h03, 8'h11, 8'h22, 8'h02, 8'h33, 8'h00});
		send_frame('{8'h03, 8'h00, 8'hFF, 8'h00});
		send_frame('{8'h02, 8'hAA, 8'h00, 8'h05, 8'h00});
		send_frame('{8'h04, 8'h01, 8'h02});
		send_frame('{8'hFF, 8'h80, 8'h7F});
		send_frame('{8'h02, 8'h99});
		// full 0xFF block: no zero owed before the next code
		frame_q.delete();
		frame_q.push_back(CodeFull);
		for (int i = 0; i < 254; i++)
			frame_q.push_back(8'(i + 1));
		frame_q.push_back(8'h03);
		frame_q.push_back(8'h00);
		frame_q.push_back(8'h5A);
		frame_q.push_back(ZeroByte);
		send_frame(frame_q);
		hold_until_drained();
		write_cap(16'd0);
		send_frame('{8'h02, 8'h41, 8'h00});
		hold_until_drained();
		// owed zero overflows the capacity
		write_cap(16'd1);
		send_frame('{8'h02, 8'h01, 8'h01, 8'h00});

		for (int ph = 0; ph < 3; ph++) begin
			src_pct = SrcIdlePct[ph];
			snk_pct = SnkIdlePct[ph];
			for (int sub = 0; sub < 3; sub++) begin
				hold_until_drained();
				if (ph == 0 && sub == 0)
					write_cap(MaxOutLenReset);
				else if ($urandom_range(3) == 0)
					write_cap(16'($urandom));
				else
					write_cap(16'($urandom_range(0, 24)));
				phase_end = sent_bytes + PhaseBytes;
				while (sent_bytes < phase_end) begin
					make_frame();
					send_frame(frame_q);
					if ($urandom_range(14) == 0)
						hold_until_drained();
				end
			end
		end

		hold_until_drained();
		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/cfd_pkg.sv
design/cfd_front.sv
design/cfd_queue.sv
design/cfd_back.sv
design/cobs_frame_decoder.sv
design/cfd_checker.sv
sim/cobs_result_checker.sv
sim/tb_cobs_frame_decoder.sv
